// ===== rtl/core/sped_pkg.sv =====
// Package with types and constants of the sparse polynomial evaluate and derive unit.
package sped_pkg;

    localparam int COEF_W  = 16;
    localparam int X_W     = 16;
    localparam int DEG_W   = 5;
    localparam int ACC_W   = 64;
    localparam int HALF_W  = ACC_W / 2;
    localparam int PROD_W  = HALF_W + X_W;
    localparam int FULL_W  = ACC_W + X_W;
    localparam int DCOEF_W = 21;

    localparam logic [ACC_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] CAP1 = 64'h8000_0000_0000_0001;

    localparam logic MODE_EVAL   = 1'b0;
    localparam logic MODE_DERIVE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_TERM,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/sparse_polynomial_eval_derive_unit.sv =====
// Sparse polynomial evaluate and derive unit with one shared 32x16 multiplier.
//
//  Channel   Direction  Handshake                  Word
//  input     in         i_in_valid / o_in_ready    coef, degree, point x, last mark
//  output    out        o_out_valid / i_out_ready  value, overflow, derived term, flags
//  config    in         i_cfg_we                   mode bit
//
// An evaluate word runs the power loop, which drives the shared multiplier over the low and
// the high half of the running product once per degree, then the term and final steps.
// A derive word goes straight to the final step. Reset is synchronous and clears the mode, the
// accumulator and the flags. A stalled output holds the unit in its final step.
module sparse_polynomial_eval_derive_unit
    import sped_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COEF_W-1:0]  i_term_coef,
    input  logic [DEG_W-1:0]          i_term_degree,
    input  logic signed [X_W-1:0]     i_point_x,
    input  logic                      i_term_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [ACC_W-1:0]   o_poly_value,
    output logic                      o_value_overflow,
    output logic signed [DCOEF_W-1:0] o_deriv_coef,
    output logic [DEG_W-1:0]          o_deriv_degree,
    output logic                      o_zero_poly,
    output logic                      o_result_last
);

    t_state r_state;
    t_state n_state;

    logic               r_mode;
    logic               r_derive;
    logic               r_cneg;
    logic               r_xneg;
    logic [COEF_W-1:0]  r_cmag;
    logic [X_W-1:0]     r_xmag;
    logic [DEG_W-1:0]   r_deg;
    logic [DEG_W-1:0]   r_cnt;
    logic               r_last;
    logic [ACC_W-1:0]   r_tmag;
    logic [PROD_W-1:0]  r_plo;
    logic [ACC_W-1:0]   r_term;
    logic [ACC_W-1:0]   r_acc;
    logic               r_ovf;
    logic               r_any;

    logic               accept;
    logic               fin_go;
    logic               emit;
    logic               out_busy;

    logic [HALF_W-1:0]  mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic [FULL_W-1:0]  full_p;
    logic [ACC_W-1:0]   sat_p;

    logic               tneg;
    logic               pos_sat;
    logic               neg_sat;
    logic [ACC_W-1:0]   term_val;
    logic               term_ovf;

    logic [ACC_W-1:0]   add_s;
    logic               add_ovf;
    logic [ACC_W-1:0]   sum_val;

    logic [DCOEF_W-1:0] dmag;
    logic [DCOEF_W-1:0] dcoef;

    assign accept   = i_in_valid && o_in_ready;
    assign out_busy = o_out_valid && !i_out_ready;

    // Shared multiplier: low half in S_MUL_LO, high half in the next cycle in S_MUL_HI.
    assign mul_a  = (r_state == S_MUL_HI) ? r_tmag[ACC_W-1:HALF_W] : r_tmag[HALF_W-1:0];
    assign mul_p  = {{X_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, r_xmag};
    assign full_p = {mul_p, {HALF_W{1'b0}}} + {{(FULL_W-PROD_W){1'b0}}, r_plo};
    assign sat_p  = (full_p > {{X_W{1'b0}}, CAP1}) ? CAP1 : full_p[ACC_W-1:0];

    assign tneg    = r_cneg ^ (r_xneg & r_deg[0]);
    assign pos_sat = r_tmag > SMAX;
    assign neg_sat = r_tmag > SMIN;

    always_comb begin
        term_val = '0;
        term_ovf = 1'b0;
        if (r_tmag != '0) begin
            if (!tneg) begin
                term_val = pos_sat ? SMAX : r_tmag;
                term_ovf = pos_sat;
            end else begin
                term_val = neg_sat ? SMIN : (~r_tmag + 1'b1);
                term_ovf = neg_sat;
            end
        end
    end

    assign add_s   = r_acc + r_term;
    assign add_ovf = (r_acc[ACC_W-1] == r_term[ACC_W-1]) &&
                     (add_s[ACC_W-1] != r_acc[ACC_W-1]);
    assign sum_val = add_ovf ? (r_acc[ACC_W-1] ? SMIN : SMAX) : add_s;

    assign dmag  = {{(DCOEF_W-COEF_W){1'b0}}, r_cmag} * {{(DCOEF_W-DEG_W){1'b0}}, r_deg};
    assign dcoef = r_cneg ? (~dmag + 1'b1) : dmag;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_mode == MODE_DERIVE) begin
                        n_state = S_FIN;
                    end else if (i_term_degree == '0) begin
                        n_state = S_TERM;
                    end else begin
                        n_state = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = (r_cnt == DEG_W'(1)) ? S_TERM : S_MUL_LO;
            S_TERM:   n_state = S_FIN;
            S_FIN:    n_state = fin_go ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        if (r_derive == MODE_DERIVE) begin
            emit = (r_deg != '0) || (r_last && !r_any);
        end else begin
            emit = r_last;
        end
        fin_go = (r_state == S_FIN) && (!emit || !out_busy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EVAL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_derive <= r_mode;
            r_cneg   <= i_term_coef[COEF_W-1];
            r_cmag   <= i_term_coef[COEF_W-1] ? (~i_term_coef + 1'b1) : i_term_coef;
            r_xneg   <= i_point_x[X_W-1];
            r_xmag   <= i_point_x[X_W-1] ? (~i_point_x + 1'b1) : i_point_x;
            r_deg    <= i_term_degree;
            r_cnt    <= i_term_degree;
            r_last   <= i_term_last;
            r_tmag   <= {{(ACC_W-COEF_W){1'b0}},
                         (i_term_coef[COEF_W-1] ? (~i_term_coef + 1'b1) : i_term_coef)};
        end else if (r_state == S_MUL_LO) begin
            r_plo <= mul_p;
        end else if (r_state == S_MUL_HI) begin
            r_tmag <= sat_p;
            r_cnt  <= r_cnt - 1'b1;
        end else if (r_state == S_TERM) begin
            r_term <= term_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_any <= 1'b0;
        end else if (r_state == S_TERM) begin
            r_ovf <= r_ovf | term_ovf;
        end else if (fin_go) begin
            if (r_last) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                r_any <= 1'b0;
            end else if (r_derive == MODE_DERIVE) begin
                if (r_deg != '0) begin
                    r_any <= 1'b1;
                end
            end else begin
                r_acc <= sum_val;
                r_ovf <= r_ovf | add_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (fin_go && emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go && emit) begin
            o_result_last <= r_last;
            if (r_derive == MODE_DERIVE) begin
                o_poly_value     <= '0;
                o_value_overflow <= 1'b0;
                if (r_deg != '0) begin
                    o_deriv_coef   <= dcoef;
                    o_deriv_degree <= r_deg - 1'b1;
                    o_zero_poly    <= 1'b0;
                end else begin
                    o_deriv_coef   <= '0;
                    o_deriv_degree <= '0;
                    o_zero_poly    <= 1'b1;
                end
            end else begin
                o_poly_value     <= sum_val;
                o_value_overflow <= r_ovf | add_ovf;
                o_deriv_coef     <= '0;
                o_deriv_degree   <= '0;
                o_zero_poly      <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/sped_chk.sv =====
// Port checker for the sparse polynomial evaluate and derive unit, with its bind.
module sped_chk
    import sped_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      o_in_ready,
    input  logic signed [COEF_W-1:0]  i_term_coef,
    input  logic [DEG_W-1:0]          i_term_degree,
    input  logic signed [X_W-1:0]     i_point_x,
    input  logic                      i_term_last,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [ACC_W-1:0]   o_poly_value,
    input  logic                      o_value_overflow,
    input  logic signed [DCOEF_W-1:0] o_deriv_coef,
    input  logic [DEG_W-1:0]          o_deriv_degree,
    input  logic                      o_zero_poly,
    input  logic                      o_result_last
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted while a word is still in work.");

    a_zero_poly_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_poly |-> o_result_last && o_deriv_coef == '0 &&
        o_poly_value == '0 && !o_value_overflow)
        else $error("Zero polynomial word is malformed.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("Result word appeared without any work in progress.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_poly_value) &&
        $stable(o_deriv_coef) && $stable(o_result_last))
        else $error("Stalled result word changed.");

endmodule

bind sparse_polynomial_eval_derive_unit sped_chk u_sped_chk (.*);
